// File: rtl/call_interval_window_monitor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the call interval window monitor
// Shared property forms; every use expects i_clk in scope, and all but the always form also i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CALL_INTERVAL_WINDOW_MONITOR_ASSERT_SVH
`define CALL_INTERVAL_WINDOW_MONITOR_ASSERT_SVH

// implication into the next cycle, off while in reset
`define CWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication, off while in reset
`define CWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, checked in reset too
`define CWM_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg
// Field widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package cwm_pkg;

    localparam int STAMP_W    = 48;
    localparam int INTERVAL_W = 31;
    localparam int SUM_OUT_W  = 37;
    localparam int WLEN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [INTERVAL_W-1:0] TARGET_RESET = 31'd1000;
    localparam logic [WLEN_W-1:0]     WLEN_RESET   = 7'd64;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_WINDOW = 2'd1
    } t_cfg_reg;

    // one classified item between front and back
    typedef struct packed {
        logic                  first;
        logic [INTERVAL_W-1:0] interval;
    } t_item;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// File: rtl/cwm_ram.sv
// ----------------------------------------------------------------------------
// cwm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cwm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cwm_front.sv
// ----------------------------------------------------------------------------
// cwm_front
// Takes call stamps, tags the first one, and forms the saturated interval.
// ----------------------------------------------------------------------------
module cwm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [cwm_pkg::STAMP_W-1:0]    i_stamp,
    input  logic                           i_full,
    output logic                           o_stall,
    output logic                           o_push,
    output cwm_pkg::t_item                 o_item
);

    logic [cwm_pkg::STAMP_W-1:0] r_last_stamp;
    logic                        r_seen_first;
    logic [cwm_pkg::STAMP_W-1:0] diff;
    logic                        accept;
    logic                        too_long;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept;

    // wraps modulo 2^48 by width
    assign diff     = i_stamp - r_last_stamp;
    assign too_long = |diff[cwm_pkg::STAMP_W-1:cwm_pkg::INTERVAL_W];

    always_comb begin
        o_item.first = !r_seen_first;
        if (!r_seen_first) begin
            o_item.interval = '0;
        end else if (too_long) begin
            o_item.interval = cwm_pkg::INTERVAL_MAX;
        end else begin
            o_item.interval = diff[cwm_pkg::INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first <= 1'b0;
            r_last_stamp <= '0;
        end else if (accept) begin
            r_seen_first <= 1'b1;
            r_last_stamp <= i_stamp;
        end
    end

endmodule

// File: rtl/cwm_queue.sv
// ----------------------------------------------------------------------------
// cwm_queue
// Two-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
module cwm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cwm_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output cwm_pkg::t_item  o_item
);

    cwm_pkg::t_item r_slot [2];
    logic [1:0]     r_count;
    logic           r_wr_ptr;
    logic           r_rd_ptr;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/cwm_back.sv
// ----------------------------------------------------------------------------
// cwm_back
// Window ring, running sum, rate decision and result register.
// ----------------------------------------------------------------------------
module cwm_back #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cwm_pkg::t_cfg_wr                  i_cfg,
    input  logic                              i_q_valid,
    input  cwm_pkg::t_item                    i_q_item,
    output logic                              o_q_pop,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic                              o_rate_ok,
    output logic [cwm_pkg::INTERVAL_W-1:0]    o_interval_us,
    output logic                              o_window_full,
    output logic [cwm_pkg::SUM_OUT_W-1:0]     o_window_sum_us
);

    localparam int WCNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = cwm_pkg::INTERVAL_W + WCNT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == LAST_SLOT) begin
            return '0;
        end
        return s + SLOT_W'(1);
    endfunction

    // configuration
    logic [cwm_pkg::INTERVAL_W-1:0] r_target;
    logic [cwm_pkg::WLEN_W-1:0]     r_window;
    logic [WCNT_W-1:0]              eff_w;
    logic [WCNT_W-1:0]              r_eff_w;
    logic [SUM_W-1:0]               r_limit;
    logic                           wr_target;
    logic                           wr_window;

    // window state
    logic [WCNT_W-1:0]              r_fill,  n_fill;
    logic [SUM_W-1:0]               r_sum,   n_sum;
    logic [SLOT_W-1:0]              r_rslot, n_rslot;
    logic [SLOT_W-1:0]              r_wslot, n_wslot;
    logic [cwm_pkg::INTERVAL_W-1:0] r_head,  n_head;
    logic                           r_ok,    n_ok;

    // ring and same-address bypass
    logic                           ram_we;
    logic [SLOT_W-1:0]              ram_raddr;
    logic [cwm_pkg::INTERVAL_W-1:0] ram_rdata;
    logic                           r_byp;
    logic [cwm_pkg::INTERVAL_W-1:0] r_byp_data;
    logic [cwm_pkg::INTERVAL_W-1:0] next_head;

    // item datapath
    logic                           pop;
    logic                           drop;
    logic [WCNT_W-1:0]              fill_mid;
    logic [SUM_W-1:0]               sum_mid;
    logic                           full_new;
    logic                           ok_new;

    // result register
    logic                           r_out_valid;
    logic                           r_out_ok;
    logic [cwm_pkg::INTERVAL_W-1:0] r_out_interval;
    logic                           r_out_full;
    logic [cwm_pkg::SUM_OUT_W-1:0]  r_out_sum;

    assign wr_target = i_cfg.valid && (i_cfg.index == cwm_pkg::CFG_TARGET);
    assign wr_window = i_cfg.valid && (i_cfg.index == cwm_pkg::CFG_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= cwm_pkg::TARGET_RESET;
            r_window <= cwm_pkg::WLEN_RESET;
        end else begin
            if (wr_target) begin
                r_target <= i_cfg.data[cwm_pkg::INTERVAL_W-1:0];
            end
            if (wr_window) begin
                r_window <= i_cfg.data[cwm_pkg::WLEN_W-1:0];
            end
        end
    end

    // zero acts as one, anything past the ring acts as the ring size
    always_comb begin
        if (r_window == '0) begin
            eff_w = WCNT_W'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            eff_w = WCNT_W'(MAX_WINDOW);
        end else begin
            eff_w = WCNT_W'(r_window);
        end
    end

    // mean < target compared as sum < target * length
    always_ff @(posedge i_clk) begin
        r_eff_w <= eff_w;
        r_limit <= SUM_W'(r_target) * SUM_W'(eff_w);
    end

    assign pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop   = pop;
    assign drop      = !i_q_item.first && (r_fill >= r_eff_w);
    assign fill_mid  = r_fill - WCNT_W'(drop);
    assign sum_mid   = r_sum - (drop ? SUM_W'(r_head) : '0);
    assign next_head = r_byp ? r_byp_data : ram_rdata;

    always_comb begin
        n_fill  = r_fill;
        n_sum   = r_sum;
        n_rslot = r_rslot;
        n_wslot = r_wslot;
        n_head  = r_head;
        n_ok    = r_ok;
        ram_we  = 1'b0;
        if (wr_window) begin
            n_fill  = '0;
            n_sum   = '0;
            n_rslot = '0;
            n_wslot = '0;
        end else if (pop && !i_q_item.first) begin
            ram_we  = 1'b1;
            n_fill  = fill_mid + WCNT_W'(1);
            n_sum   = sum_mid + SUM_W'(i_q_item.interval);
            n_wslot = slot_inc(r_wslot);
            if (drop) begin
                n_rslot = slot_inc(r_rslot);
            end
            if (fill_mid == '0) begin
                n_head = i_q_item.interval;
            end else if (drop) begin
                n_head = next_head;
            end
            if (n_fill >= r_eff_w) begin
                n_ok = (n_sum < r_limit);
            end
        end
    end

    assign full_new = (n_fill >= r_eff_w);
    assign ok_new   = n_ok;

    // keep the entry after the oldest one ready for the next drop
    assign ram_raddr = slot_inc(n_rslot);

    cwm_ram #(
        .WIDTH (cwm_pkg::INTERVAL_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (i_q_item.interval),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_q_item.interval;
        r_head     <= n_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_sum   <= '0;
            r_rslot <= '0;
            r_wslot <= '0;
            r_ok    <= 1'b1;
            r_byp   <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_rslot <= n_rslot;
            r_wslot <= n_wslot;
            r_ok    <= n_ok;
            r_byp   <= ram_we && (r_wslot == ram_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_ok       <= ok_new;
            r_out_interval <= i_q_item.interval;
            r_out_full     <= full_new;
            r_out_sum      <= cwm_pkg::SUM_OUT_W'(n_sum);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rate_ok       = r_out_ok;
    assign o_interval_us   = r_out_interval;
    assign o_window_full   = r_out_full;
    assign o_window_sum_us = r_out_sum;

endmodule

// File: rtl/call_interval_window_monitor.sv
// ----------------------------------------------------------------------------
// call_interval_window_monitor
// Sliding-window check of the mean spacing between call events.
// ----------------------------------------------------------------------------
// Each accepted timestamp gives one result. The first call after reset only
// records its stamp; every later call yields the interval since the previous
// one (modulo 2^48, clamped to 2^31-1), which enters a window of the last
// window_length intervals with an exact running sum. Once the window is full,
// rate_ok reports sum < target * length; until then it keeps its last value
// (set after reset). Writing window_length empties the window. The block takes
// one item per clock, sustained, while the output is not stalled; each item
// passes through the two-entry queue and its result is registered in the
// output register. That rate is set by the back stage, which drops the oldest
// interval from a prefetched head register, writes the ring RAM and updates
// the sum once per cycle. The queue separates stamp intake from the window
// update, so input stall rises only after the output has been stalled. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module call_interval_window_monitor #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [cwm_pkg::STAMP_W-1:0]        i_timestamp_us,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_rate_ok,
    output logic [cwm_pkg::INTERVAL_W-1:0]     o_interval_us,
    output logic                               o_window_full,
    output logic [cwm_pkg::SUM_OUT_W-1:0]      o_window_sum_us,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    cwm_pkg::t_item   push_item;
    cwm_pkg::t_item   q_item;
    cwm_pkg::t_cfg_wr cfg;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    cwm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_stamp (i_timestamp_us),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_item  (push_item)
    );

    cwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cwm_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_rate_ok       (o_rate_ok),
        .o_interval_us   (o_interval_us),
        .o_window_full   (o_window_full),
        .o_window_sum_us (o_window_sum_us)
    );

endmodule

// File: rtl/cwm_checker.sv
// ----------------------------------------------------------------------------
// cwm_checker
// Port-level checks on the call interval window monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "call_interval_window_monitor_assert.svh"

module cwm_checker #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_stall,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic                               o_rate_ok,
    input  logic [cwm_pkg::INTERVAL_W-1:0]     o_interval_us,
    input  logic                               o_window_full,
    input  logic [cwm_pkg::SUM_OUT_W-1:0]      o_window_sum_us
);

    logic small_ring;

    // sum field is exact only while the window fits 37 bits
    assign small_ring = (MAX_WINDOW <= 64);

    `CWM_ASSERT_NEXT_ALWAYS(a_reset_quiet, !i_rst_n, !o_out_valid && !o_in_stall, "not idle after reset")
    `CWM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_rate_ok) && $stable(o_interval_us) && $stable(o_window_full) && $stable(o_window_sum_us), "stalled result changed")
    `CWM_ASSERT_NOW(a_sum_has_interval, o_out_valid && small_ring, o_window_sum_us >= o_interval_us, "window sum below newest interval")
    `CWM_ASSERT_NEXT(a_stall_drains, o_in_stall && !i_out_stall, !o_in_stall, "input stall held while output drains")

endmodule

bind call_interval_window_monitor cwm_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_cwm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_rate_ok       (o_rate_ok),
    .o_interval_us   (o_interval_us),
    .o_window_full   (o_window_full),
    .o_window_sum_us (o_window_sum_us)
);
